// File: hdl/rme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_pkg
// Shared widths, codes and defaults for the register machine executor.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int OP_W        = 4;
    localparam int RIDX_IN_W   = 4;
    localparam int TGT_W       = 8;
    localparam int WORD_W      = 32;
    localparam int PC_W        = 9;
    localparam int STAT_W      = 2;
    localparam int KIND_W      = 2;

    localparam int IN_FIELDS_W  = OP_W + 2 * RIDX_IN_W + TGT_W + WORD_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = PC_W + STAT_W + KIND_W + WORD_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int PROGRAM_DEPTH     = 256;
    localparam int NUM_REGISTERS_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ZERO    = 4'd0,
        OP_SUCC    = 4'd1,
        OP_COPY    = 4'd2,
        OP_JUMP    = 4'd3,
        OP_READNUM = 4'd4,
        OP_READCHR = 4'd5,
        OP_PRTNUM  = 4'd6,
        OP_PRTCHR  = 4'd7
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_EXEC    = 2'd0,
        ST_INVALID = 2'd1,
        ST_HALTED  = 2'd2
    } t_status;

    typedef enum logic [KIND_W-1:0] {
        PK_NONE = 2'd0,
        PK_NUM  = 2'd1,
        PK_CHR  = 2'd2
    } t_print;

endpackage

// File: hdl/rme_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// File: hdl/register_machine_executor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_machine_executor_core
// Executes one register machine instruction per request and returns the
// next program counter, a status and any print output.
// ----------------------------------------------------------------------------
//  channel   | dir | fields (lowest bit first)
//  ----------+-----+-------------------------------------------------------
//  s_axis    | in  | operation, operand_a, operand_b, jump_target, read_value
//  m_axis    | out | next_pc, status, print_kind, print_value
//  cfg       | in  | program_length
//
//  One request per cycle while results are taken; the register file is read at
//  the accepting edge into the execute stage, and a result is valid once the
//  execute stage advances into the result register.
//  Reset clears the program counter, the program length, the register valid
//  bits and both pipeline stages.
//  A stalled result holds the execute stage; s_axis_tready drops only when
//  both stages are full and the result is not taken.
// ----------------------------------------------------------------------------
module register_machine_executor_core #(
    parameter int NUM_REGISTERS = rme_pkg::NUM_REGISTERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rme_pkg::PC_W-1:0]       i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // operation[3:0], operand_a[7:4], operand_b[11:8], jump_target[19:12],
    // read_value[51:20], zero pad
    input  logic [rme_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // next_pc[8:0], status[10:9], print_kind[12:11], print_value[44:13],
    // zero pad
    output logic [rme_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import rme_pkg::*;

    localparam int RIDX_W = $clog2(NUM_REGISTERS);

    localparam int A_LSB  = OP_W;
    localparam int B_LSB  = A_LSB + RIDX_IN_W;
    localparam int T_LSB  = B_LSB + RIDX_IN_W;
    localparam int RV_LSB = T_LSB + TGT_W;

    // configuration and architectural state
    logic [PC_W-1:0]          r_len;
    logic [PC_W-1:0]          r_pc;
    logic [PC_W-1:0]          n_pc;
    logic [NUM_REGISTERS-1:0] r_valid;

    // execute stage
    logic                 r_s1_vld;
    logic [OP_W-1:0]      r_op;
    logic [RIDX_IN_W-1:0] r_a;
    logic [RIDX_IN_W-1:0] r_b;
    logic [TGT_W-1:0]     r_tgt;
    logic [WORD_W-1:0]    r_rv;
    logic                 r_rd_vld_a;
    logic                 r_rd_vld_b;

    // last register file write, for bypass
    logic              r_wr_vld;
    logic [RIDX_W-1:0] r_wr_idx;
    logic [WORD_W-1:0] r_wr_data;

    // result register
    logic              r_out_vld;
    logic [PC_W-1:0]   r_out_pc;
    logic [STAT_W-1:0] r_out_stat;
    logic [KIND_W-1:0] r_out_kind;
    logic [WORD_W-1:0] r_out_pval;

    logic                 accept;
    logic                 advance;
    logic [RIDX_IN_W-1:0] in_a;
    logic [RIDX_IN_W-1:0] in_b;
    logic [RIDX_W-1:0]    rd_idx_a;
    logic [RIDX_W-1:0]    rd_idx_b;
    logic [WORD_W-1:0]    ram_a;
    logic [WORD_W-1:0]    ram_b;

    logic [RIDX_W-1:0] idx_a;
    logic [RIDX_W-1:0] idx_b;
    logic              a_ok;
    logic              b_ok;
    logic [WORD_W-1:0] val_a;
    logic [WORD_W-1:0] val_b;
    logic              halted;
    logic              we;
    logic [RIDX_W-1:0] w_idx;
    logic [WORD_W-1:0] w_data;
    logic              w_ok;
    logic              do_wr;
    logic [STAT_W-1:0] n_stat;
    logic [KIND_W-1:0] n_kind;
    logic [WORD_W-1:0] n_pval;

    assign advance       = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_a     = s_axis_tdata[A_LSB +: RIDX_IN_W];
    assign in_b     = s_axis_tdata[B_LSB +: RIDX_IN_W];
    assign rd_idx_a = RIDX_W'(in_a);
    assign rd_idx_b = RIDX_W'(in_b);

    rme_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_REGISTERS)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_we      (do_wr),
        .i_waddr   (w_idx),
        .i_wdata   (w_data),
        .i_re      (accept),
        .i_raddr_a (rd_idx_a),
        .i_raddr_b (rd_idx_b),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // operand fetch with bypass of the last write
    always_comb begin
        idx_a = RIDX_W'(r_a);
        idx_b = RIDX_W'(r_b);
        a_ok  = 32'(r_a) < 32'(NUM_REGISTERS);
        b_ok  = 32'(r_b) < 32'(NUM_REGISTERS);
        if (!a_ok) begin
            val_a = '0;
        end else if (r_wr_vld && r_wr_idx == idx_a) begin
            val_a = r_wr_data;
        end else begin
            val_a = r_rd_vld_a ? ram_a : '0;
        end
        if (!b_ok) begin
            val_b = '0;
        end else if (r_wr_vld && r_wr_idx == idx_b) begin
            val_b = r_wr_data;
        end else begin
            val_b = r_rd_vld_b ? ram_b : '0;
        end
    end

    // execute
    always_comb begin
        halted = (32'(r_pc) >= 32'(r_len)) || (32'(r_pc) >= 32'(PROGRAM_DEPTH));
        n_pc   = r_pc + PC_W'(1);
        n_stat = ST_EXEC;
        n_kind = PK_NONE;
        n_pval = '0;
        we     = 1'b0;
        w_idx  = idx_a;
        w_ok   = a_ok;
        w_data = '0;
        unique case (r_op) inside
            OP_ZERO: begin
                we = 1'b1;
            end
            OP_SUCC: begin
                we     = 1'b1;
                w_data = val_a + WORD_W'(1);
            end
            OP_COPY: begin
                we     = 1'b1;
                w_idx  = idx_b;
                w_ok   = b_ok;
                w_data = val_a;
            end
            OP_JUMP: begin
                if (val_a == val_b) begin
                    n_pc = PC_W'(r_tgt);
                end
            end
            OP_READNUM, OP_READCHR: begin
                we     = 1'b1;
                w_data = r_rv;
            end
            OP_PRTNUM: begin
                n_kind = PK_NUM;
                n_pval = val_a;
            end
            OP_PRTCHR: begin
                n_kind = PK_CHR;
                n_pval = val_a;
            end
            default: begin
                n_stat = ST_INVALID;
            end
        endcase
        if (halted) begin
            n_pc   = r_pc;
            n_stat = ST_HALTED;
            n_kind = PK_NONE;
            n_pval = '0;
            we     = 1'b0;
        end
        do_wr = advance && we && w_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_pc      <= '0;
            r_valid   <= '0;
            r_s1_vld  <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (advance) begin
                r_pc <= n_pc;
            end
            if (do_wr) begin
                r_valid[w_idx] <= 1'b1;
                r_wr_vld       <= 1'b1;
            end
            r_s1_vld  <= accept || (r_s1_vld && !advance);
            r_out_vld <= advance || (r_out_vld && !m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= s_axis_tdata[0 +: OP_W];
            r_a        <= in_a;
            r_b        <= in_b;
            r_tgt      <= s_axis_tdata[T_LSB +: TGT_W];
            r_rv       <= s_axis_tdata[RV_LSB +: WORD_W];
            r_rd_vld_a <= r_valid[rd_idx_a];
            r_rd_vld_b <= r_valid[rd_idx_b];
        end
        if (do_wr) begin
            r_wr_idx  <= w_idx;
            r_wr_data <= w_data;
        end
        if (advance) begin
            r_out_pc   <= n_pc;
            r_out_stat <= n_stat;
            r_out_kind <= n_kind;
            r_out_pval <= n_pval;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                            r_out_pval, r_out_kind, r_out_stat, r_out_pc};

endmodule

// File: test/register_machine_executor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_machine_executor_core_tb
// Drives instruction requests into the executor and checks every result
// against a cycle-free model of the machine: register file, program counter
// and program length. A directed run covers wrap, copy, jumps taken and not
// taken, prints, invalid opcodes and halting. Random phases follow, each with
// its own program length and idling mix. Requests steer the counter back
// before the end of the program, so most of the run executes.
// ----------------------------------------------------------------------------
module register_machine_executor_core_tb;
    import rme_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 750;
    localparam int PHASE_ITEMS  = 60;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [RIDX_IN_W-1:0] ra;
        logic [RIDX_IN_W-1:0] rb;
        logic [TGT_W-1:0]     target;
        logic [WORD_W-1:0]    rval;
    } t_exec_req;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        t_status           status;
        t_print            kind;
        logic [WORD_W-1:0] pval;
    } t_exec_res;

    class rme_scoreboard;
        logic [WORD_W-1:0] regs [NUM_REGISTERS_DEF];
        logic [PC_W-1:0]   pc;
        logic [PC_W-1:0]   length;
        t_exec_res         pending [$];
        int unsigned       errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc = '0;
            length = '0;
            errors = 0;
        endfunction

        function logic [PC_W-1:0] eff_len();
            return (length > PC_W'(PROGRAM_DEPTH)) ? PC_W'(PROGRAM_DEPTH) : length;
        endfunction

        function bit halted();
            return pc >= eff_len();
        endfunction

        function void note_request(t_exec_req r);
            t_exec_res       e;
            logic [PC_W-1:0] nxt;
            e = '{next_pc: pc, status: ST_HALTED, kind: PK_NONE, pval: '0};
            if (!halted()) begin
                nxt = pc + 1'b1;
                e.status = ST_EXEC;
                case (r.op) inside
                    OP_ZERO: regs[r.ra] = '0;
                    OP_SUCC: regs[r.ra] = regs[r.ra] + 1'b1;
                    OP_COPY: regs[r.rb] = regs[r.ra];
                    OP_JUMP: if (regs[r.ra] == regs[r.rb]) nxt = PC_W'(r.target);
                    OP_READNUM, OP_READCHR: regs[r.ra] = r.rval;
                    OP_PRTNUM: begin
                        e.kind = PK_NUM;
                        e.pval = regs[r.ra];
                    end
                    OP_PRTCHR: begin
                        e.kind = PK_CHR;
                        e.pval = regs[r.ra];
                    end
                    default: e.status = ST_INVALID;
                endcase
                pc = nxt;
                e.next_pc = pc;
            end
            pending.push_back(e);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100) $display("%0t mismatch: %s", $time, what);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] d);
            t_exec_res         e;
            logic [PC_W-1:0]   got_pc;
            logic [STAT_W-1:0] got_st;
            logic [KIND_W-1:0] got_kind;
            logic [WORD_W-1:0] got_val;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending, tdata %h", d));
                return;
            end
            e = pending.pop_front();
            got_pc   = d[PC_W-1:0];
            got_st   = d[PC_W +: STAT_W];
            got_kind = d[PC_W + STAT_W +: KIND_W];
            got_val  = d[PC_W + STAT_W + KIND_W +: WORD_W];
            if (got_pc !== e.next_pc)
                report($sformatf("next_pc got %0d want %0d", got_pc, e.next_pc));
            if (got_st !== e.status)
                report($sformatf("status got %0d want %0d", got_st, e.status));
            if (got_kind !== e.kind)
                report($sformatf("print_kind got %0d want %0d", got_kind, e.kind));
            if (got_val !== e.pval)
                report($sformatf("print_value got %h want %h", got_val, e.pval));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [PC_W-1:0]        i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    rme_scoreboard sb;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    bit            hold_req = 1'b0;
    int            executed = 0;

    register_machine_executor_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_exec_req instr(logic [OP_W-1:0] op, int a, int b, int t,
                                        logic [WORD_W-1:0] rv);
        t_exec_req r;
        r.op = op;
        r.ra = RIDX_IN_W'(a);
        r.rb = RIDX_IN_W'(b);
        r.target = TGT_W'(t);
        r.rval = rv;
        return r;
    endfunction

    function automatic t_exec_req random_request();
        t_exec_req       r;
        logic [PC_W-1:0] lim;
        int              pick;
        lim = sb.eff_len();
        pick = $urandom_range(99);
        r.op = (pick < 8) ? OP_W'($urandom_range(15, 8)) : OP_W'($urandom_range(7));
        r.ra = RIDX_IN_W'($urandom_range(15));
        r.rb = ($urandom_range(99) < 30) ? r.ra : RIDX_IN_W'($urandom_range(15));
        if (lim != 0 && $urandom_range(99) < 85)
            r.target = TGT_W'($urandom_range(lim - 1));
        else
            r.target = TGT_W'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 40)      r.rval = $urandom_range(3);
        else if (pick < 50) r.rval = '1;
        else if (pick < 55) r.rval = 32'h7fff_ffff;
        else if (pick < 60) r.rval = 32'h8000_0000;
        else                r.rval = $urandom;
        // jump back before running off the end of the program
        if (!sb.halted() && sb.pc + 1 >= lim &&
            (lim == PC_W'(PROGRAM_DEPTH) || $urandom_range(99) < 90)) begin
            r.op = OP_JUMP;
            r.rb = r.ra;
            r.target = TGT_W'($urandom_range(lim - 1));
        end
        return r;
    endfunction

    task automatic send_request(t_exec_req r);
        s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}},
                          r.rval, r.target, r.rb, r.ra, r.op};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(logic [PC_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.length = v;
        i_cfg_we    <= 1'b0;
    endtask

    // result side: check, then decide tready for the next edge
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("register_machine_executor_core_tb: errors");
        $finish;
    end

    initial begin
        t_exec_req dir [$];
        int        lengths [8];
        int        phase;
        int        n;
        int        halted_run;
        sb = new();
        lengths = '{256, 5, 511, 1, 300, 0, 256, 37};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // length is zero out of reset: halted, read ignored
        send_request(instr(OP_READNUM, 5, 0, 0, 123));
        write_length(PC_W'(256));

        dir.push_back(instr(OP_READNUM, 0, 0, 0, 32'h7fff_ffff));
        dir.push_back(instr(OP_SUCC, 0, 0, 0, 0));
        dir.push_back(instr(OP_READNUM, 15, 0, 0, 32'hffff_ffff));
        dir.push_back(instr(OP_SUCC, 15, 0, 0, 0));
        dir.push_back(instr(OP_READCHR, 1, 0, 0, 32'h41));
        dir.push_back(instr(OP_PRTNUM, 0, 0, 0, 0));
        dir.push_back(instr(OP_PRTCHR, 1, 0, 0, 0));
        dir.push_back(instr(OP_COPY, 0, 14, 0, 0));
        dir.push_back(instr(OP_PRTNUM, 14, 0, 0, 0));
        dir.push_back(instr(OP_JUMP, 0, 14, 255, 0));
        dir.push_back(instr(OP_JUMP, 2, 3, 0, 0));
        dir.push_back(instr(OP_JUMP, 0, 1, 200, 0));
        dir.push_back(instr(OP_ZERO, 0, 0, 0, 0));
        dir.push_back(instr(OP_PRTNUM, 0, 0, 0, 0));
        dir.push_back(instr(4'd15, 15, 15, 255, 32'hffff_ffff));
        dir.push_back(instr(4'd8, 0, 0, 0, 0));
        dir.push_back(instr(OP_READNUM, 3, 0, 0, 32'h8000_0000));
        dir.push_back(instr(OP_PRTCHR, 3, 0, 0, 0));
        dir.push_back(instr(OP_PRTNUM, 15, 0, 0, 0));
        foreach (dir[i]) send_request(dir[i]);

        // jump past a short program, halt, then resume with a longer one
        write_length(PC_W'(10));
        send_request(instr(OP_JUMP, 4, 4, 200, 0));
        send_request(instr(OP_PRTNUM, 0, 0, 0, 0));
        write_length(PC_W'(256));
        send_request(instr(OP_PRTNUM, 0, 0, 0, 0));

        for (phase = 0; executed < RANDOM_ITEMS || phase < 8; phase++) begin
            if (!sb.halted()) send_request(instr(OP_JUMP, 0, 0, 0, 0));
            write_length((phase % 8 == 7) ? PC_W'($urandom_range(255, 2))
                                          : PC_W'(lengths[phase % 8]));
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 88;
                end
                default: begin
                    send_idle_pct = 13;
                    recv_stall_pct = 13;
                end
            endcase
            if (phase == 0) hold_req = 1'b1;
            halted_run = 0;
            for (n = 0; n < PHASE_ITEMS && halted_run < 6; n++) begin
                if (sb.halted()) halted_run++;
                else executed++;
                send_request(random_request());
                if (phase == 2 && n == PHASE_ITEMS / 2) drain();
            end
        end

        drain();
        if (sb.pending.size() != 0) sb.report("results still pending at end of run");
        if (sb.errors == 0)
            $display("register_machine_executor_core_tb: clean");
        else
            $display("register_machine_executor_core_tb: errors");
        $finish;
    end

endmodule
